// File: rtl/rbd_pkg.sv
// Shared types and constants for the RGBA 2x2 box downscaler.
package rbd_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int TOT_W      = PIX_W + 2;
    localparam int NUM_CH     = 4;
    localparam int TDATA_W    = NUM_CH * PIX_W;
    localparam int LINE_W     = NUM_CH * SUM_W;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_cfg_reg;

    // Channel 0 is red in the lowest bits, then green, blue and alpha.
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_pixel;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sum;

endpackage

// File: rtl/rbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/rgba_box_downscale_2x_unit.sv
// Top level of the RGBA 2x2 box downscaler.
//
// Source pixels enter on the s_axis channel in raster order, one item per
// pixel, and half-size destination pixels leave on the m_axis channel. Each
// destination channel is the truncating average of a 2x2 source block; an axis
// of size 1 is not halved, and an odd trailing column or row of a larger image
// is dropped. m_axis_tlast marks the final destination pixel of an image.
// The image size is set through the configuration channel (index 0 is the
// width, index 1 the height); a write also restarts the frame. The ready of
// that channel is always high. The user must make writes only while the block
// is idle; the block does not enforce this. Throughput is one source item per
// clock while the receiver takes results. The item that completes a block goes
// into the stage register, with the line store read, then the output register.
// Pair sums of even rows sit in a line store of (MAX_WIDTH+1)/2 words that is
// read by the odd row below; its contents are never cleared.
// Reset empties the pipeline, sets the image size to 1x1 and restarts the
// frame. When the receiver stalls, the output register holds its item, the
// stage register can still fill, and then s_axis_tready drops.
module rgba_box_downscale_2x_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Source pixel stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rbd_pkg::TDATA_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    // Destination pixel stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rbd_pkg::TDATA_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                             m_axis_tlast   // frame_last
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int WDW        = $clog2(MAX_WIDTH + 1);
    localparam int HDW        = $clog2(MAX_HEIGHT + 1);

    // Effective (clamped) image size.
    logic [WDW-1:0] r_eff_w, n_eff_w;
    logic [HDW-1:0] r_eff_h, n_eff_h;

    // Raster position of the next source pixel.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Even-column pixel waiting for its right-hand partner.
    rbd_pkg::t_pixel r_held;

    // Stage register.
    logic            r_s1_valid;
    rbd_pkg::t_sum   r_s1_hsum;
    logic            r_s1_add_line;
    logic [1:0]      r_s1_shift;
    logic            r_s1_last;

    // Output register.
    logic            r_out_valid;
    rbd_pkg::t_pixel r_out_pix, n_out_pix;
    logic            r_out_last;

    logic            cfg_fire;
    logic            in_fire;
    logic            adv;
    logic            w_one, h_one;
    rbd_pkg::t_pixel px;
    rbd_pkg::t_sum   hsum;
    rbd_pkg::t_sum   line_rd;
    logic            hready, emit, add_line, line_wr;
    logic [1:0]      shift;
    logic [WDW-1:0]  col_p1;
    logic [HDW-1:0]  row_p1;
    logic            last_x, last_y;
    logic [LINE_AW-1:0] slot;
    logic [rbd_pkg::LINE_W-1:0] line_rd_raw;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    // The stage register moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Clamp a written size to 1..MAX; the counters restart on any write.
    always_comb begin
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        if (cfg_fire) begin
            unique case (rbd_pkg::t_cfg_reg'(i_cfg_index))
                rbd_pkg::REG_SRC_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_eff_w = WDW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                        n_eff_w = WDW'(MAX_WIDTH);
                    end else begin
                        n_eff_w = WDW'(i_cfg_data);
                    end
                end
                rbd_pkg::REG_SRC_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_eff_h = HDW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                        n_eff_h = HDW'(MAX_HEIGHT);
                    end else begin
                        n_eff_h = HDW'(i_cfg_data);
                    end
                end
                default: begin
                    n_eff_w = r_eff_w;
                end
            endcase
        end
    end

    // Work done at acceptance: horizontal pair sum, line store traffic and
    // the position bookkeeping.
    always_comb begin
        px     = rbd_pkg::t_pixel'(s_axis_tdata);
        w_one  = (r_eff_w == WDW'(1));
        h_one  = (r_eff_h == HDW'(1));
        col_p1 = WDW'(r_col) + WDW'(1);
        row_p1 = HDW'(r_row) + HDW'(1);
        slot   = LINE_AW'(r_col >> 1);

        for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
            if (w_one) begin
                hsum[k] = {1'b0, px[k]};
            end else begin
                hsum[k] = {1'b0, r_held[k]} + {1'b0, px[k]};
            end
        end

        // A horizontal sum is complete on odd columns, or on every pixel of
        // a single-column image.
        hready   = w_one || r_col[0];
        add_line = !h_one && r_row[0];
        emit     = hready && (h_one || r_row[0]);
        line_wr  = hready && !h_one && !r_row[0] && (row_p1 < r_eff_h);
        shift    = 2'(!w_one) + 2'(add_line);

        last_x = w_one || ((WDW'(r_col >> 1) + WDW'(1)) == (r_eff_w >> 1));
        last_y = h_one || ((HDW'(r_row >> 1) + HDW'(1)) == (r_eff_h >> 1));

        n_col = r_col;
        n_row = r_row;
        if (cfg_fire) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (col_p1 == r_eff_w) begin
                n_col = '0;
                n_row = (row_p1 == r_eff_h) ? '0 : RW'(row_p1);
            end else begin
                n_col = CW'(col_p1);
            end
        end
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire && line_wr),
        .i_wr_addr (slot),
        .i_wr_data (hsum),
        .i_rd_en   (in_fire && emit && add_line),
        .i_rd_addr (slot),
        .o_rd_data (line_rd_raw)
    );

    assign line_rd = rbd_pkg::t_sum'(line_rd_raw);

    // Vertical completion and the final divide by shifting.
    always_comb begin
        logic [rbd_pkg::TOT_W-1:0] total;
        for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
            total = {1'b0, r_s1_hsum[k]};
            if (r_s1_add_line) begin
                total = total + {1'b0, line_rd[k]};
            end
            n_out_pix[k] = rbd_pkg::PIX_W'(total >> r_s1_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= WDW'(1);
            r_eff_h     <= HDW'(1);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eff_w <= n_eff_w;
            r_eff_h <= n_eff_h;
            r_col   <= n_col;
            r_row   <= n_row;
            if (in_fire) begin
                r_s1_valid <= emit;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !hready) begin
            r_held <= px;
        end
        if (in_fire && emit) begin
            r_s1_hsum     <= hsum;
            r_s1_add_line <= add_line;
            r_s1_shift    <= shift;
            r_s1_last     <= last_x && last_y;
        end
        if (adv && r_s1_valid) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/rbd_chk.sv
// Port-level checker for the RGBA 2x2 box downscaler, with its bind.
module rbd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rbd_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast
);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // An empty output fills only from an accepted item that passed the stage register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a recent input item");

    // A receiver that takes results never holds up the source.
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("source stalled while receiver is ready");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind rgba_box_downscale_2x_unit rbd_chk u_rbd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
